@@ sv/nnps_pkg.sv @@
// ----------------------------------------------------------------------------
// nnps_pkg
// Shared constants, register codes, types and helpers of the nearest-neighbour
// pixel scaler.
// ----------------------------------------------------------------------------
package nnps_pkg;

	localparam int MAX_DIM     = 4096;
	localparam int MAX_SCALE   = 8;
	localparam int FRAC_BITS   = 16;
	localparam int DIM_W       = 13;
	localparam int PIXEL_W     = 32;
	localparam int ADDR_W      = 24;
	localparam int ALPHA_LSB   = 24;
	localparam int ALPHA_W     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CNT_W       = $clog2(MAX_DIM);
	localparam int RATIO_W     = FRAC_BITS + $clog2(MAX_SCALE) + 1;
	localparam int ACC_W       = CNT_W + RATIO_W - 1;
	localparam int POS_W       = ACC_W - FRAC_BITS;
	localparam int SPAN_W      = $clog2(MAX_SCALE) + 1;
	localparam int STEP_W      = $clog2(MAX_SCALE);
	localparam int QUEUE_DEPTH = 4;

	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;
	localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(MAX_SCALE) << FRAC_BITS;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH       = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT      = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_DEST_PITCH       = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_TRANSPARENT = CFG_IDX_W'(5);

	typedef struct packed {
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] src_height;
		logic [DIM_W-1:0] dest_width;
		logic [DIM_W-1:0] dest_height;
		logic [DIM_W-1:0] dest_pitch;
		logic             skip_transparent;
	} cfg_t;

	// One source pixel together with the destination block it covers.
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [POS_W-1:0]   x0;
		logic [SPAN_W-1:0]  xspan;
		logic [SPAN_W-1:0]  yspan;
		logic [ADDR_W-1:0]  base;
	} job_t;

	// A size of zero acts as one, a size above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ sv/nnps_ratio_div.sv @@
// ----------------------------------------------------------------------------
// nnps_ratio_div
// Restoring divider for one scale ratio: (dest << FRAC_BITS) / src, one
// quotient bit per cycle, clamped to the largest scale.
// ----------------------------------------------------------------------------
module nnps_ratio_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nnps_pkg::DIM_W-1:0]    dst_size,
	input  logic [nnps_pkg::DIM_W-1:0]    src_size,
	output logic [nnps_pkg::RATIO_W-1:0]  ratio,
	output logic                          busy
);

	localparam int DIM_W   = nnps_pkg::DIM_W;
	localparam int RATIO_W = nnps_pkg::RATIO_W;
	localparam int HEAD_W  = RATIO_W - nnps_pkg::FRAC_BITS;
	localparam int STEP_CW = $clog2(RATIO_W);

	logic [DIM_W-1:0]   dst_c;
	logic [DIM_W-1:0]   src_c;
	logic               overflow;
	logic [DIM_W:0]     trial;
	logic [DIM_W:0]     diff;
	logic               ge;
	logic [RATIO_W-1:0] quo_next;

	logic               busy_q;
	logic [STEP_CW-1:0] step_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [DIM_W-1:0]   rem_q;
	logic [DIM_W-1:0]   dvs_q;
	logic [RATIO_W-1:0] num_q;
	logic [RATIO_W-1:0] quo_q;

	always_comb begin
		dst_c    = nnps_pkg::clamp_dim(dst_size);
		src_c    = nnps_pkg::clamp_dim(src_size);
		// A quotient that would not fit the ratio width is clamped at once.
		overflow = (DIM_W + HEAD_W)'(dst_c) >= {src_c, {HEAD_W{1'b0}}};
		trial    = {rem_q, num_q[RATIO_W-1]};
		diff     = trial - (DIM_W + 1)'(dvs_q);
		ge       = trial >= (DIM_W + 1)'(dvs_q);
		quo_next = {quo_q[RATIO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			ratio_q <= nnps_pkg::RATIO_ONE;
		end else if (start) begin
			step_q <= '0;
			if (overflow) begin
				busy_q  <= 1'b0;
				ratio_q <= nnps_pkg::RATIO_MAX;
			end else begin
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			step_q <= step_q + STEP_CW'(1);
			if (step_q == STEP_CW'(RATIO_W - 1)) begin
				busy_q  <= 1'b0;
				ratio_q <= (quo_next > nnps_pkg::RATIO_MAX) ? nnps_pkg::RATIO_MAX : quo_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dst_c >> HEAD_W;
			dvs_q <= src_c;
			num_q <= {dst_c[HEAD_W-1:0], {nnps_pkg::FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
			num_q <= {num_q[RATIO_W-2:0], 1'b0};
			quo_q <= quo_next;
		end
	end

	assign ratio = ratio_q;
	assign busy  = busy_q;

endmodule

@@ sv/nnps_front.sv @@
// ----------------------------------------------------------------------------
// nnps_front
// Accepts source pixels, tracks the raster position, works out the
// destination block of each pixel and queues it unless it is dropped.
// ----------------------------------------------------------------------------
module nnps_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nnps_pkg::cfg_t                cfg,
	input  logic [nnps_pkg::RATIO_W-1:0]  width_ratio_next,
	input  logic [nnps_pkg::RATIO_W-1:0]  height_ratio_next,
	input  logic                          hold,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  logic [nnps_pkg::PIXEL_W-1:0]  src_pixel,
	input  logic                          queue_full,
	output logic                          push,
	output nnps_pkg::job_t                job
);

	localparam int CNT_W     = nnps_pkg::CNT_W;
	localparam int ACC_W     = nnps_pkg::ACC_W;
	localparam int DIM_W     = nnps_pkg::DIM_W;
	localparam int RATIO_W   = nnps_pkg::RATIO_W;
	localparam int FRAC_BITS = nnps_pkg::FRAC_BITS;
	localparam int POS_W     = nnps_pkg::POS_W;
	localparam int SPAN_W    = nnps_pkg::SPAN_W;

	logic [CNT_W-1:0]   col_count_q;
	logic [CNT_W-1:0]   row_count_q;
	logic [ACC_W-1:0]   col_accum_q;
	logic [ACC_W-1:0]   row_accum_q;
	logic [RATIO_W-1:0] width_ratio_q;
	logic [RATIO_W-1:0] height_ratio_q;

	logic                      accept;
	logic                      frame_start;
	logic [RATIO_W-1:0]        wr_eff;
	logic [RATIO_W-1:0]        hr_eff;
	logic [RATIO_W:0]          x_sum;
	logic [RATIO_W:0]          y_sum;
	logic [SPAN_W-1:0]         xspan;
	logic [SPAN_W-1:0]         yspan;
	logic [POS_W-1:0]          y0;
	logic [POS_W+DIM_W-1:0]    base_full;
	logic [nnps_pkg::ALPHA_W-1:0] alpha;
	logic                      drop;
	logic [DIM_W-1:0]          col_inc;
	logic [DIM_W-1:0]          row_inc;
	logic                      col_wrap;
	logic                      row_wrap;

	always_comb begin
		src_ready   = !queue_full && !hold;
		accept      = src_valid && src_ready;
		frame_start = (col_count_q == '0) && (row_count_q == '0);
		// The first pixel of a frame takes up the freshly computed ratios.
		wr_eff      = frame_start ? width_ratio_next : width_ratio_q;
		hr_eff      = frame_start ? height_ratio_next : height_ratio_q;
		// Block size is the carry out of the fraction plus the ratio.
		x_sum       = (RATIO_W + 1)'(col_accum_q[FRAC_BITS-1:0]) + (RATIO_W + 1)'(wr_eff);
		y_sum       = (RATIO_W + 1)'(row_accum_q[FRAC_BITS-1:0]) + (RATIO_W + 1)'(hr_eff);
		xspan       = x_sum[FRAC_BITS +: SPAN_W];
		yspan       = y_sum[FRAC_BITS +: SPAN_W];
		y0          = row_accum_q[ACC_W-1:FRAC_BITS];
		base_full   = y0 * cfg.dest_pitch;
		alpha       = src_pixel[nnps_pkg::ALPHA_LSB +: nnps_pkg::ALPHA_W];
		drop        = (cfg.skip_transparent && (alpha == '0)) || (xspan == '0) || (yspan == '0);
		push        = accept && !drop;

		job.pixel   = src_pixel;
		job.x0      = col_accum_q[ACC_W-1:FRAC_BITS];
		job.xspan   = xspan;
		job.yspan   = yspan;
		job.base    = base_full[nnps_pkg::ADDR_W-1:0];

		col_inc     = DIM_W'(col_count_q) + DIM_W'(1);
		row_inc     = DIM_W'(row_count_q) + DIM_W'(1);
		col_wrap    = col_inc >= nnps_pkg::clamp_dim(cfg.src_width);
		row_wrap    = row_inc >= nnps_pkg::clamp_dim(cfg.src_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q    <= '0;
			row_count_q    <= '0;
			col_accum_q    <= '0;
			row_accum_q    <= '0;
			width_ratio_q  <= nnps_pkg::RATIO_ONE;
			height_ratio_q <= nnps_pkg::RATIO_ONE;
		end else if (accept) begin
			if (frame_start) begin
				width_ratio_q  <= width_ratio_next;
				height_ratio_q <= height_ratio_next;
			end
			if (col_wrap) begin
				col_count_q <= '0;
				col_accum_q <= '0;
				if (row_wrap) begin
					row_count_q <= '0;
					row_accum_q <= '0;
				end else begin
					row_count_q <= row_inc[CNT_W-1:0];
					row_accum_q <= row_accum_q + ACC_W'(hr_eff);
				end
			end else begin
				col_count_q <= col_inc[CNT_W-1:0];
				col_accum_q <= col_accum_q + ACC_W'(wr_eff);
			end
		end
	end

endmodule

@@ sv/nnps_queue.sv @@
// ----------------------------------------------------------------------------
// nnps_queue
// Short first-in first-out queue of pixel jobs between front and back.
// ----------------------------------------------------------------------------
module nnps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nnps_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           job_valid,
	output nnps_pkg::job_t rd_job
);

	localparam int DEPTH = nnps_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	nnps_pkg::job_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = count_q == (PTR_W + 1)'(DEPTH);
	assign job_valid = count_q != '0;
	assign rd_job    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

@@ sv/nnps_back.sv @@
// ----------------------------------------------------------------------------
// nnps_back
// Walks the destination block of the job at the queue head, row by row and
// left to right, driving one word per cycle into the free output register.
// ----------------------------------------------------------------------------
module nnps_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  nnps_pkg::job_t                job,
	output logic                          pop,
	input  logic [nnps_pkg::DIM_W-1:0]    dest_pitch,
	output logic                          dest_valid,
	input  logic                          dest_ready,
	output logic [nnps_pkg::ADDR_W-1:0]   dest_address,
	output logic [nnps_pkg::PIXEL_W-1:0]  out_pixel,
	output logic                          run_last
);

	localparam int ADDR_W = nnps_pkg::ADDR_W;
	localparam int SPAN_W = nnps_pkg::SPAN_W;
	localparam int STEP_W = nnps_pkg::STEP_W;

	logic [STEP_W-1:0]  xi_q;
	logic [STEP_W-1:0]  yi_q;
	logic [ADDR_W-1:0]  row_off_q;
	logic               dest_valid_q;
	logic [ADDR_W-1:0]  dest_address_q;
	logic [nnps_pkg::PIXEL_W-1:0] out_pixel_q;
	logic               run_last_q;

	logic              advance;
	logic              last_x;
	logic              last_y;
	logic [ADDR_W-1:0] addr;

	always_comb begin
		advance = job_valid && (!dest_valid_q || dest_ready);
		last_x  = SPAN_W'(xi_q) == (job.xspan - SPAN_W'(1));
		last_y  = SPAN_W'(yi_q) == (job.yspan - SPAN_W'(1));
		pop     = advance && last_x && last_y;
		addr    = job.base + row_off_q + ADDR_W'(job.x0) + ADDR_W'(xi_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xi_q         <= '0;
			yi_q         <= '0;
			row_off_q    <= '0;
			dest_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				dest_valid_q <= 1'b1;
				if (last_x) begin
					xi_q <= '0;
					if (last_y) begin
						yi_q      <= '0;
						row_off_q <= '0;
					end else begin
						yi_q      <= yi_q + STEP_W'(1);
						row_off_q <= row_off_q + ADDR_W'(dest_pitch);
					end
				end else begin
					xi_q <= xi_q + STEP_W'(1);
				end
			end else if (dest_ready) begin
				dest_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dest_address_q <= addr;
			out_pixel_q    <= job.pixel;
			run_last_q     <= last_x && last_y;
		end
	end

	assign dest_valid   = dest_valid_q;
	assign dest_address = dest_address_q;
	assign out_pixel    = out_pixel_q;
	assign run_last     = run_last_q;

endmodule

@@ sv/nearest_neighbor_pixel_scaler_core.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_pixel_scaler_core
// Nearest-neighbour scaler: replicates raster-order source pixels into their
// destination blocks and emits each destination pixel with its address.
// ----------------------------------------------------------------------------
// Usage. Source pixels enter on the src channel (src_valid, src_ready,
// src_pixel) in raster order. Each destination word leaves on the dest channel
// (dest_valid, dest_ready, dest_address, out_pixel, run_last); run_last marks
// the final word of the block produced by one source pixel. A source pixel
// whose block is empty, or a transparent pixel when skipping is enabled,
// produces no word but still advances the raster position.
// Registers are written through the cfg channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); the user must write them only while the block is
// idle, which the block itself does not enforce. After every write the two
// scale ratios are recomputed by bit-serial dividers; src_ready stays low
// while they run. The ratios are taken up at the first pixel of each frame.
// With an empty queue and a free output register, an accepted pixel is first
// written into the job queue and its first word then into the output register.
// Throughput: the back end emits one word per cycle while the receiver is
// ready, and each queued pixel's block has at least one and at most 64 words;
// a twofold upscale gives four words per pixel. A four-entry job queue lets
// the front keep accepting while the back end works or the receiver stalls; a
// stalled receiver holds the output word and in time fills the queue.
// Reset clears the position, the queue and the output valid flag and restores
// all sizes to one, the ratios to one and transparency skipping to off.
// ----------------------------------------------------------------------------
module nearest_neighbor_pixel_scaler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_ready,
	input  logic [nnps_pkg::PIXEL_W-1:0]   src_pixel,
	output logic                           dest_valid,
	input  logic                           dest_ready,
	output logic [nnps_pkg::ADDR_W-1:0]    dest_address,
	output logic [nnps_pkg::PIXEL_W-1:0]   out_pixel,
	output logic                           run_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nnps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnps_pkg::DIM_W-1:0]     cfg_data
);

	nnps_pkg::cfg_t cfg_q;
	logic           div_start_q;

	logic [nnps_pkg::RATIO_W-1:0] width_ratio_next;
	logic [nnps_pkg::RATIO_W-1:0] height_ratio_next;
	logic                         width_busy;
	logic                         height_busy;
	logic                         hold;

	logic           push;
	nnps_pkg::job_t wr_job;
	logic           queue_full;
	logic           pop;
	logic           job_valid;
	nnps_pkg::job_t rd_job;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width        <= nnps_pkg::DIM_W'(1);
			cfg_q.src_height       <= nnps_pkg::DIM_W'(1);
			cfg_q.dest_width       <= nnps_pkg::DIM_W'(1);
			cfg_q.dest_height      <= nnps_pkg::DIM_W'(1);
			cfg_q.dest_pitch       <= nnps_pkg::DIM_W'(1);
			cfg_q.skip_transparent <= 1'b0;
			div_start_q            <= 1'b0;
		end else begin
			// The dividers start in the cycle after a write, once the new size
			// is in its register.
			div_start_q <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					nnps_pkg::REG_SRC_WIDTH: begin
						cfg_q.src_width <= cfg_data;
					end
					nnps_pkg::REG_SRC_HEIGHT: begin
						cfg_q.src_height <= cfg_data;
					end
					nnps_pkg::REG_DEST_WIDTH: begin
						cfg_q.dest_width <= cfg_data;
					end
					nnps_pkg::REG_DEST_HEIGHT: begin
						cfg_q.dest_height <= cfg_data;
					end
					nnps_pkg::REG_DEST_PITCH: begin
						cfg_q.dest_pitch <= cfg_data;
					end
					nnps_pkg::REG_SKIP_TRANSPARENT: begin
						cfg_q.skip_transparent <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	nnps_ratio_div u_width_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dst_size (cfg_q.dest_width),
		.src_size (cfg_q.src_width),
		.ratio    (width_ratio_next),
		.busy     (width_busy)
	);

	nnps_ratio_div u_height_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dst_size (cfg_q.dest_height),
		.src_size (cfg_q.src_height),
		.ratio    (height_ratio_next),
		.busy     (height_busy)
	);

	// No pixel is taken while a ratio is still being worked out.
	assign hold = div_start_q || width_busy || height_busy;

	nnps_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.width_ratio_next  (width_ratio_next),
		.height_ratio_next (height_ratio_next),
		.hold              (hold),
		.src_valid         (src_valid),
		.src_ready         (src_ready),
		.src_pixel         (src_pixel),
		.queue_full        (queue_full),
		.push              (push),
		.job               (wr_job)
	);

	nnps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.full      (queue_full),
		.pop       (pop),
		.job_valid (job_valid),
		.rd_job    (rd_job)
	);

	nnps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (rd_job),
		.pop          (pop),
		.dest_pitch   (cfg_q.dest_pitch),
		.dest_valid   (dest_valid),
		.dest_ready   (dest_ready),
		.dest_address (dest_address),
		.out_pixel    (out_pixel),
		.run_last     (run_last)
	);

endmodule

@@ sv/nnps_checker.sv @@
// ----------------------------------------------------------------------------
// nnps_checker
// Port-level checks on the scaler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module nnps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           src_ready,
	input logic                           dest_valid,
	input logic                           dest_ready,
	input logic [nnps_pkg::ADDR_W-1:0]    dest_address,
	input logic [nnps_pkg::PIXEL_W-1:0]   out_pixel,
	input logic                           run_last,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);

	// A stalled output word holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		dest_valid && !dest_ready |=> dest_valid && $stable(dest_address)
			&& $stable(out_pixel) && $stable(run_last))
	else $error("output word changed while stalled");

	// A register write restarts the ratio dividers, which hold off pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !src_ready)
	else $error("pixel input open right after a register write");

	// Once reset has been seen at an edge, nothing is offered on the output
	// at the following edge.
	assert property (@(posedge clk)
		!arst_n |=> !dest_valid)
	else $error("output valid during reset");

endmodule

bind nearest_neighbor_pixel_scaler_core nnps_checker u_nnps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.src_ready    (src_ready),
	.dest_valid   (dest_valid),
	.dest_ready   (dest_ready),
	.dest_address (dest_address),
	.out_pixel    (out_pixel),
	.run_last     (run_last),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
